### rtl/bbrf_pkg.sv
`default_nettype none

package bbrf_pkg;

  // Field widths
  localparam int COORD_W   = 10;
  localparam int BAND_W    = 8;
  localparam int BYTE_IX_W = 12;
  localparam int COUNT_W   = 21;
  localparam int LIMIT_W   = 11;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 10;
  localparam int DIV_NUM_W = COORD_W + BAND_W;  // panel_height * band
  localparam int DIV_CNT_W = 5;

  // Item kinds
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_FILL  = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // Result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD_BAND = 2'd1;
  localparam logic [1:0] STATUS_BEYOND   = 2'd2;
  localparam logic [1:0] STATUS_RESERVED = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PANEL_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PANEL_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_COUNT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_COLOR  = 2'd3;

  // Register reset values
  localparam logic [COORD_W-1:0] PANEL_WIDTH_RST  = 10'd800;
  localparam logic [COORD_W-1:0] PANEL_HEIGHT_RST = 10'd480;
  localparam logic [BAND_W-1:0]  BAND_COUNT_RST   = 8'd12;

  localparam logic [7:0] BYTE_WHITE = 8'hFF;
  localparam logic [7:0] MASK_MSB   = 8'h80;

  typedef struct packed {
    logic [1:0]           kind;
    logic [BAND_W-1:0]    band;
    logic [COORD_W-1:0]   x_first;
    logic [COORD_W-1:0]   y_first;
    logic [COORD_W-1:0]   x_end;
    logic [COORD_W-1:0]   y_end;
    logic [BYTE_IX_W-1:0] byte_index;
  } in_word_t;

  typedef struct packed {
    logic [7:0]         data_byte;
    logic [COUNT_W-1:0] pixels_written;
    logic [1:0]         status;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CLEAR,
    ST_DIV1_GO,
    ST_DIV1_RUN,
    ST_DIV2_GO,
    ST_DIV2_RUN,
    ST_FILL_PREP,
    ST_FILL_MUL,
    ST_FILL_WALK,
    ST_FILL_DRAIN,
    ST_READ_ISSUE,
    ST_READ_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic clear_step;
    logic div_start;
    logic div_sel_first;
    logic first_load;
    logic limit_load;
    logic fill_prep;
    logic fill_mul;
    logic fill_issue;
    logic read_issue;
    logic read_capture;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       band_bad;
    logic       clear_last;
    logic       div_done;
    logic       fill_empty;
    logic       walk_last;
  } sts_t;

endpackage

`default_nettype wire

### rtl/bbrf_ram.sv
`default_nettype none

module bbrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/bbrf_div.sv
`default_nettype none

module bbrf_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [bbrf_pkg::DIV_NUM_W-1:0] numerator,
  input  logic [bbrf_pkg::BAND_W-1:0]    divisor,
  output logic                           done,
  output logic [bbrf_pkg::DIV_NUM_W-1:0] quotient
);

  import bbrf_pkg::*;

  // restoring division, one quotient bit per cycle
  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_NUM_W-1:0] num_sh;
  logic [BAND_W-1:0]    rem;
  logic [BAND_W:0]      rem_sh;
  logic [BAND_W:0]      rem_sub;
  logic                 ge;

  assign rem_sh  = {rem, num_sh[DIV_NUM_W-1]};
  assign ge      = rem_sh >= {1'b0, divisor};
  assign rem_sub = rem_sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_sh   <= numerator;
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      num_sh   <= {num_sh[DIV_NUM_W-2:0], 1'b0};
      rem      <= ge ? rem_sub[BAND_W-1:0] : rem_sh[BAND_W-1:0];
      quotient <= {quotient[DIV_NUM_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

### rtl/bbrf_datapath.sv
`default_nettype none

module bbrf_datapath #(
  parameter int BAND_BYTES = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bbrf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bbrf_pkg::CFG_DAT_W-1:0] cfg_data,
  input  bbrf_pkg::in_word_t             item,
  input  bbrf_pkg::cmd_t                 cmd,
  output bbrf_pkg::sts_t                 sts,
  output bbrf_pkg::out_word_t            result
);

  import bbrf_pkg::*;

  localparam int AW        = $clog2(BAND_BYTES);
  localparam int BAND_BITS = BAND_BYTES * 8;

  // configuration
  logic [COORD_W-1:0] panel_width;
  logic [COORD_W-1:0] panel_height;
  logic [BAND_W-1:0]  band_count;
  logic               plane_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      panel_width  <= PANEL_WIDTH_RST;
      panel_height <= PANEL_HEIGHT_RST;
      band_count   <= BAND_COUNT_RST;
      plane_color  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PANEL_WIDTH:  panel_width  <= cfg_data[COORD_W-1:0];
        CFG_PANEL_HEIGHT: panel_height <= cfg_data[COORD_W-1:0];
        CFG_BAND_COUNT:   band_count   <= cfg_data[BAND_W-1:0];
        CFG_PLANE_COLOR:  plane_color  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // latched word
  in_word_t item_q;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_q <= item;
    end
  end

  // band bounds
  logic [COORD_W-1:0]   band_first_row;
  logic [LIMIT_W-1:0]   band_row_limit;
  logic [DIV_NUM_W-1:0] band_prod;
  logic [DIV_NUM_W-1:0] div_num;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] div_quo;

  assign band_prod = {{BAND_W{1'b0}}, panel_height} * {{COORD_W{1'b0}}, item_q.band};
  assign div_num   = cmd.div_sel_first ? band_prod : {{BAND_W{1'b0}}, panel_height};

  bbrf_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .numerator (div_num),
    .divisor   (band_count),
    .done      (div_done),
    .quotient  (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      band_first_row <= '0;
      band_row_limit <= '0;
    end else begin
      if (cmd.first_load) begin
        band_first_row <= div_quo[COORD_W-1:0];
      end
      if (cmd.limit_load) begin
        band_row_limit <= {1'b0, band_first_row} + {1'b0, div_quo[COORD_W-1:0]};
      end
    end
  end

  // clear sweep
  logic [AW-1:0] clr_cnt;
  logic          clear_last;

  assign clear_last = clr_cnt == AW'(BAND_BYTES - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_step) begin
      clr_cnt <= clear_last ? '0 : clr_cnt + 1'b1;
    end
  end

  // fill setup
  logic [COORD_W-1:0] y0_c;
  logic [COORD_W-1:0] yh_c;
  logic [COORD_W-1:0] y1_c;
  logic [COORD_W-1:0] x1_c;
  logic [COORD_W-1:0] y_off;
  logic [COORD_W-1:0] y1;
  logic [COORD_W-1:0] x1;
  logic [COORD_W-1:0] xcur;
  logic [COORD_W-1:0] ycur;
  logic [COUNT_W-1:0] row_base;
  logic               fill_empty;

  assign y0_c = (item_q.y_first > band_first_row) ? item_q.y_first : band_first_row;
  assign yh_c = (item_q.y_end < panel_height) ? item_q.y_end : panel_height;
  assign y1_c = (band_row_limit < {1'b0, yh_c}) ? band_row_limit[COORD_W-1:0] : yh_c;
  assign x1_c = (item_q.x_end < panel_width) ? item_q.x_end : panel_width;

  // walk, issue stage
  logic [COUNT_W-1:0] bit_ix;
  logic               px_beyond;
  logic               x_last;
  logic               y_last;

  assign bit_ix    = row_base + COUNT_W'(xcur);
  assign px_beyond = bit_ix >= COUNT_W'(BAND_BITS);
  assign x_last    = ({1'b0, xcur} + 1'b1) == {1'b0, x1};
  assign y_last    = ({1'b0, ycur} + 1'b1) == {1'b0, y1};

  always_ff @(posedge clk) begin
    if (cmd.fill_prep) begin
      y_off      <= y0_c - band_first_row;
      y1         <= y1_c;
      x1         <= x1_c;
      ycur       <= y0_c;
      xcur       <= item_q.x_first;
      fill_empty <= (y0_c >= y1_c) || (item_q.x_first >= x1_c);
    end else if (cmd.fill_mul) begin
      row_base <= COUNT_W'(y_off * panel_width);
    end else if (cmd.fill_issue) begin
      if (x_last) begin
        xcur     <= item_q.x_first;
        ycur     <= ycur + 1'b1;
        row_base <= row_base + COUNT_W'(panel_width);
      end else begin
        xcur <= xcur + 1'b1;
      end
    end
  end

  // walk, modify stage
  logic          s1_valid;
  logic [AW-1:0] s1_idx;
  logic [2:0]    s1_sel;
  logic          fwd_valid;
  logic [AW-1:0] fwd_idx;
  logic [7:0]    fwd_data;
  logic [7:0]    ram_rdata;
  logic [7:0]    cur_byte;
  logic [7:0]    px_mask;
  logic [7:0]    new_byte;

  // last write lands on the same edge as this read, so bypass it
  assign cur_byte = (fwd_valid && fwd_idx == s1_idx) ? fwd_data : ram_rdata;
  assign px_mask  = MASK_MSB >> s1_sel;
  assign new_byte = plane_color ? (cur_byte | px_mask) : (cur_byte & ~px_mask);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      s1_valid  <= cmd.fill_issue && !px_beyond;
      fwd_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx   <= bit_ix[AW+2:3];
    s1_sel   <= bit_ix[2:0];
    fwd_idx  <= s1_idx;
    fwd_data <= new_byte;
  end

  logic [COUNT_W-1:0] pix_count;
  logic               beyond;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix_count <= '0;
      beyond    <= 1'b0;
    end else begin
      if (s1_valid) begin
        pix_count <= pix_count + 1'b1;
      end
      if (cmd.fill_issue && px_beyond) begin
        beyond <= 1'b1;
      end
    end
  end

  // buffer
  logic [16:0]   byte_ix_ext;
  logic          read_beyond;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    rd_byte;

  assign byte_ix_ext = 17'(item_q.byte_index);
  assign read_beyond = byte_ix_ext >= 17'(BAND_BYTES);
  assign ram_we      = cmd.clear_step || s1_valid;
  assign ram_waddr   = cmd.clear_step ? clr_cnt : s1_idx;
  assign ram_wdata   = cmd.clear_step ? BYTE_WHITE : new_byte;
  assign ram_raddr   = cmd.read_issue ? byte_ix_ext[AW-1:0] : bit_ix[AW+2:3];

  bbrf_ram #(
    .WIDTH (8),
    .DEPTH (BAND_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.read_capture) begin
      rd_byte <= ram_rdata;
    end
  end

  // result word
  out_word_t res_c;

  always_comb begin
    res_c = '0;
    case (item_q.kind)
      KIND_START: begin
        res_c.status = (item_q.band >= band_count) ? STATUS_BAD_BAND : STATUS_OK;
      end
      KIND_FILL: begin
        res_c.pixels_written = pix_count;
        res_c.status         = beyond ? STATUS_BEYOND : STATUS_OK;
      end
      KIND_READ: begin
        res_c.data_byte = read_beyond ? 8'd0 : rd_byte;
        res_c.status    = read_beyond ? STATUS_BEYOND : STATUS_OK;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result <= res_c;
    end
  end

  assign sts.kind       = item_q.kind;
  assign sts.band_bad   = item_q.band >= band_count;
  assign sts.clear_last = clear_last;
  assign sts.div_done   = div_done;
  assign sts.fill_empty = fill_empty;
  assign sts.walk_last  = x_last && y_last;

endmodule

`default_nettype wire

### rtl/bbrf_ctrl.sv
`default_nettype none

module bbrf_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  output logic           result_valid,
  input  logic           result_stall,
  input  bbrf_pkg::sts_t sts,
  output bbrf_pkg::cmd_t cmd
);

  import bbrf_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign item_stall = state != ST_IDLE;
  assign out_free   = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (sts.kind)
          KIND_START: state_next = sts.band_bad ? ST_DONE : ST_CLEAR;
          KIND_FILL:  state_next = ST_FILL_PREP;
          KIND_READ:  state_next = ST_READ_ISSUE;
          default:    state_next = ST_DONE;
        endcase
      end
      ST_CLEAR: begin
        if (sts.clear_last) begin
          state_next = ST_DIV1_GO;
        end
      end
      ST_DIV1_GO:  state_next = ST_DIV1_RUN;
      ST_DIV1_RUN: begin
        if (sts.div_done) begin
          state_next = ST_DIV2_GO;
        end
      end
      ST_DIV2_GO:  state_next = ST_DIV2_RUN;
      ST_DIV2_RUN: begin
        if (sts.div_done) begin
          state_next = ST_DONE;
        end
      end
      ST_FILL_PREP: state_next = ST_FILL_MUL;
      ST_FILL_MUL:  state_next = sts.fill_empty ? ST_DONE : ST_FILL_WALK;
      ST_FILL_WALK: begin
        if (sts.walk_last) begin
          state_next = ST_FILL_DRAIN;
        end
      end
      ST_FILL_DRAIN: state_next = ST_DONE;
      ST_READ_ISSUE: state_next = ST_READ_WAIT;
      ST_READ_WAIT:  state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE:       cmd.accept        = item_valid;
      ST_CLEAR:      cmd.clear_step    = 1'b1;
      ST_DIV1_GO: begin
        cmd.div_start     = 1'b1;
        cmd.div_sel_first = 1'b1;
      end
      ST_DIV1_RUN:   cmd.first_load    = sts.div_done;
      ST_DIV2_GO:    cmd.div_start     = 1'b1;
      ST_DIV2_RUN:   cmd.limit_load    = sts.div_done;
      ST_FILL_PREP:  cmd.fill_prep     = 1'b1;
      ST_FILL_MUL:   cmd.fill_mul      = 1'b1;
      ST_FILL_WALK:  cmd.fill_issue    = 1'b1;
      ST_READ_ISSUE: cmd.read_issue    = 1'b1;
      ST_READ_WAIT:  cmd.read_capture  = 1'b1;
      ST_DONE:       cmd.out_load      = out_free;
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/banded_bitplane_rect_fill_top.sv
`default_nettype none

// Banded 1-bpp rectangle fill buffer. Holds one horizontal band of a panel,
// one bit per pixel, MSB first, row stride panel_width bits. Each accepted
// word gives exactly one result word. Words are taken one at a time; the next
// word is accepted while the previous result still waits in the output
// register. What each kind of word does:
//   start band  : A sweep writes 0xFF into every buffer byte, one byte per
//                 cycle through the single write port, then a bit-serial
//                 divider runs twice (each run: a start state, 18 quotient
//                 bits and the load) for the band's first row and row count.
//                 An out-of-range band goes straight to the result and leaves
//                 the buffer alone.
//   fill        : walks the pixels of the rectangle clipped to panel
//                 and band (pixels past the buffer end are walked but not
//                 written). One pixel per cycle: read, modify, write through
//                 a two-stage pipe on the buffer RAM with a bypass of the
//                 previous write. An empty rectangle skips the walk.
//   read byte   : an issue state, then capture of the registered RAM read.
//   other kinds : no buffer work; the result word is all zeros.
// The buffer content is undefined until the first good start-band word.
// Configuration writes are always taken (cfg_ready is tied high) and must
// only come while the block is idle.

module banded_bitplane_rect_fill_top #(
  parameter int BAND_BYTES = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  // item channel
  input  logic                           item_valid,
  output logic                           item_stall,
  input  bbrf_pkg::in_word_t             item,
  // result channel
  output logic                           result_valid,
  input  logic                           result_stall,
  output bbrf_pkg::out_word_t            result,
  // register writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bbrf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bbrf_pkg::CFG_DAT_W-1:0] cfg_data
);

  import bbrf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  // sequencer: one state per phase of the current word
  bbrf_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  // registers, band bounds, divider, fill walker, buffer RAM, result word
  bbrf_datapath #(
    .BAND_BYTES (BAND_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .cmd       (cmd),
    .sts       (sts),
    .result    (result)
  );

endmodule

`default_nettype wire

### rtl/bbrf_checker.sv
`default_nettype none

module bbrf_checker (
  input logic                clk,
  input logic                rst,
  input logic                item_valid,
  input logic                item_stall,
  input logic                result_valid,
  input logic                result_stall,
  input bbrf_pkg::out_word_t result
);

  import bbrf_pkg::*;

  // one word in flight: stall right after an accept
  a_stall_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("accepted a word without stalling the next");

  a_reset_clears_result: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result dropped or changed");

  a_no_reserved_status: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.status != STATUS_RESERVED)
    else $error("reserved status code");

  a_bad_band_empty: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == STATUS_BAD_BAND
      |-> result.pixels_written == '0 && result.data_byte == '0)
    else $error("bad-band result carries data");

endmodule

bind banded_bitplane_rect_fill_top bbrf_checker u_checker (.*);

`default_nettype wire

### dv/testbench.sv
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bbrf_pkg::*;

  localparam int BAND_BYTES   = 4096;
  localparam int PHASE_WORDS  = 160;     // random words per register setting
  localparam int WALK_CAP     = 36000;   // max clipped pixels per random fill
  localparam int STUCK_LIMIT  = 150000;  // cycles with no handshake at all
  localparam int DRAIN_CYCLES = 64;
  localparam int PRINT_CAP    = 200;

  // kind 3: block answers all zeros and keeps its state
  localparam logic [1:0] KIND_IDLE = 2'd3;

  logic                 clk;
  logic                 rst;
  logic                 item_valid;
  logic                 item_stall;
  in_word_t             item;
  logic                 result_valid;
  logic                 result_stall;
  out_word_t            result;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  banded_bitplane_rect_fill_top #(
    .BAND_BYTES(BAND_BYTES)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the band buffer, its band selection and the registers.
  // Updated at the edge where a word or a register write is taken.
  // ---------------------------------------------------------------------------
  logic [7:0]         shadow_buf [BAND_BYTES];
  logic [COORD_W-1:0] shadow_width;
  logic [COORD_W-1:0] shadow_height;
  logic [BAND_W-1:0]  shadow_bands;
  logic               shadow_red;
  logic [COORD_W-1:0] shadow_first_row;
  logic [LIMIT_W-1:0] shadow_row_limit;
  bit                 buffer_live;  // a good start-band word has been taken

  out_word_t answers_due [$];       // expected result words, oldest first
  int        mismatches = 0;
  bit        item_gaps_on = 1'b1;
  bit        stall_on = 1'b1;

  // directed stimulus rows: either a register write or a word
  typedef struct {
    bit                   is_reg;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [CFG_DAT_W-1:0] reg_value;
    in_word_t             word;
    bit                   typed;
    out_word_t            want;
  } plan_row_t;

  plan_row_t plan [$];

  function automatic int lesser(int a, int b);
    return (a < b) ? a : b;
  endfunction

  function automatic int greater(int a, int b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [COORD_W-1:0] to_coord(int v);
    return COORD_W'((v < 0) ? 0 : (v > 1023) ? 1023 : v);
  endfunction

  // Applies one taken word to the shadow state and returns its result word.
  function automatic out_word_t draw_word(in_word_t w);
    out_word_t  ans;
    int         y_lo;
    int         y_hi;
    int         x_hi;
    int         y;
    int         x;
    int         pix;
    int         idx;
    logic [7:0] mask;
    ans = '0;
    case (w.kind)
      KIND_START: begin
        // band_count of zero lands here too, so no divide by zero below
        if (w.band >= shadow_bands) begin
          ans.status = STATUS_BAD_BAND;
        end else begin
          foreach (shadow_buf[i]) shadow_buf[i] = BYTE_WHITE;
          shadow_first_row = COORD_W'(int'(shadow_height) * int'(w.band)
                                      / int'(shadow_bands));
          shadow_row_limit = LIMIT_W'(int'(shadow_first_row)
                                      + int'(shadow_height) / int'(shadow_bands));
          buffer_live = 1'b1;
        end
      end
      KIND_FILL: begin
        // clip to panel and band; x is only clipped on the right
        y_lo = greater(int'(w.y_first), int'(shadow_first_row));
        y_hi = lesser(lesser(int'(w.y_end), int'(shadow_height)), int'(shadow_row_limit));
        x_hi = lesser(int'(w.x_end), int'(shadow_width));
        for (y = y_lo; y < y_hi; y++) begin
          for (x = int'(w.x_first); x < x_hi; x++) begin
            pix = (y - int'(shadow_first_row)) * int'(shadow_width) + x;
            idx = pix >> 3;
            if (idx >= BAND_BYTES) begin
              ans.status = STATUS_BEYOND;
              continue;
            end
            mask = MASK_MSB >> pix[2:0];
            shadow_buf[idx] = shadow_red ? (shadow_buf[idx] | mask)
                                         : (shadow_buf[idx] & ~mask);
            ans.pixels_written = ans.pixels_written + 1'b1;
          end
        end
      end
      KIND_READ: begin
        if (int'(w.byte_index) < BAND_BYTES) ans.data_byte = shadow_buf[w.byte_index];
        else ans.status = STATUS_BEYOND;
      end
      default: begin
      end
    endcase
    return ans;
  endfunction

  // exp_data of -1 leaves the row to the shadow model
  function automatic void plan_word(logic [1:0] kind, int band, int xf, int yf, int xe,
                                    int ye, int bi, int exp_data = -1, int exp_count = 0,
                                    logic [1:0] exp_status = STATUS_OK);
    plan_row_t r;
    r.is_reg               = 1'b0;
    r.reg_index            = '0;
    r.reg_value            = '0;
    r.word.kind            = kind;
    r.word.band            = band[BAND_W-1:0];
    r.word.x_first         = xf[COORD_W-1:0];
    r.word.y_first         = yf[COORD_W-1:0];
    r.word.x_end           = xe[COORD_W-1:0];
    r.word.y_end           = ye[COORD_W-1:0];
    r.word.byte_index      = bi[BYTE_IX_W-1:0];
    r.typed                = (exp_data >= 0);
    r.want.data_byte       = exp_data[7:0];
    r.want.pixels_written  = exp_count[COUNT_W-1:0];
    r.want.status          = exp_status;
    plan.push_back(r);
  endfunction

  function automatic void plan_reg(logic [CFG_IDX_W-1:0] index, int value);
    plan_row_t r;
    r.is_reg    = 1'b1;
    r.reg_index = index;
    r.reg_value = value[CFG_DAT_W-1:0];
    r.word      = '0;
    r.typed     = 1'b0;
    r.want      = '0;
    plan.push_back(r);
  endfunction

  task automatic report_mismatch(string what);
    // keep the log bounded when the block is badly off
    if (mismatches < PRINT_CAP) $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Register writes only go out with the block idle: nothing left pending.
  // cfg_valid is left high after the write; the next word lowers it.
  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DAT_W-1:0] value);
    item_valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (index)
      CFG_PANEL_WIDTH:  shadow_width  = value[COORD_W-1:0];
      CFG_PANEL_HEIGHT: shadow_height = value[COORD_W-1:0];
      CFG_BAND_COUNT:   shadow_bands  = value[BAND_W-1:0];
      CFG_PLANE_COLOR:  shadow_red    = value[0];
      default: begin
      end
    endcase
  endtask

  // Drives one word. Valid stays high after the handshake so back-to-back
  // words never lower and raise it in the same step.
  task automatic send_item(in_word_t w, bit typed, out_word_t want);
    int        gap;
    out_word_t got;
    gap = item_gaps_on ? $urandom_range(0, 9) : 0;
    cfg_valid <= 1'b0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item       <= w;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    got = draw_word(w);
    answers_due.push_back(typed ? want : got);
    if ($urandom_range(0, 63) == 0) item_gaps_on = !item_gaps_on;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall before each word, then check it field by field.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int        hold;
    out_word_t want;
    result_stall = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      hold = stall_on ? $urandom_range(0, 9) : 0;
      if (hold > 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      result_stall <= 1'b0;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
      if (answers_due.size() == 0) begin
        report_mismatch($sformatf("result word %h with nothing pending", result));
      end else begin
        want = answers_due.pop_front();
        if (result.data_byte !== want.data_byte)
          report_mismatch($sformatf("data_byte %h, want %h",
                                    result.data_byte, want.data_byte));
        if (result.pixels_written !== want.pixels_written)
          report_mismatch($sformatf("pixels_written %0d, want %0d",
                                    result.pixels_written, want.pixels_written));
        if (result.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", result.status, want.status));
      end
      if ($urandom_range(0, 63) == 0) stall_on = !stall_on;
    end
  end

  // Watchdog: a start band sweeps the whole buffer and a large fill walks
  // every clipped pixel, so a long stretch with no handshake means a hang.
  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
          (cfg_valid && cfg_ready))
        stuck = 0;
      else
        stuck++;
    end
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus: directed rows at reset settings, then random phases.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int       ph_width  [9] = '{800, 1023, 1, 1023, 64, 1023, 640, -1, -1};
    int       ph_height [9] = '{480, 1023, 1, 1023, 100, 1, 384, -1, -1};
    int       ph_bands  [9] = '{12, 30, 1, 255, 255, 1, 0, -1, -1};
    int       ph_red    [9] = '{1, 0, 1, 1, 0, 0, 1, -1, -1};
    int       ph;
    int       pick;
    int       rows;
    int       top;
    int       span;
    int       walk;
    in_word_t w;

    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;

    // shadow state after reset; buffer content is unknown until a start
    foreach (shadow_buf[i]) shadow_buf[i] = 8'h00;
    shadow_width     = PANEL_WIDTH_RST;
    shadow_height    = PANEL_HEIGHT_RST;
    shadow_bands     = BAND_COUNT_RST;
    shadow_red       = 1'b0;
    shadow_first_row = '0;
    shadow_row_limit = '0;
    buffer_live      = 1'b0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // --- directed rows, reset settings: 800x480, 12 bands, black plane ---
    plan_word(KIND_START, 12, 0, 0, 0, 0, 0, 0, 0, STATUS_BAD_BAND);
    plan_word(KIND_START, 255, 0, 0, 0, 0, 0, 0, 0, STATUS_BAD_BAND);
    plan_word(KIND_IDLE, 255, 1023, 1023, 1023, 1023, 4095, 0, 0, STATUS_OK);
    // row limit is still zero, so nothing lands and no byte is touched
    plan_word(KIND_FILL, 0, 0, 0, 800, 480, 0, 0, 0, STATUS_OK);
    plan_word(KIND_START, 0, 0, 0, 0, 0, 0, 0, 0, STATUS_OK);
    plan_word(KIND_READ, 0, 0, 0, 0, 0, 0, 8'hFF, 0, STATUS_OK);
    plan_word(KIND_READ, 0, 0, 0, 0, 0, 4095, 8'hFF, 0, STATUS_OK);
    plan_word(KIND_FILL, 0, 0, 0, 1, 1, 0, 0, 1, STATUS_OK);
    plan_word(KIND_READ, 0, 0, 0, 0, 0, 0, 8'h7F, 0, STATUS_OK);
    // empty rectangles, in x and in y
    plan_word(KIND_FILL, 0, 5, 0, 5, 10, 0, 0, 0, STATUS_OK);
    plan_word(KIND_FILL, 0, 0, 7, 10, 7, 0, 0, 0, STATUS_OK);
    // clipped at the right panel edge, then at the band bottom
    plan_word(KIND_FILL, 0, 790, 0, 1023, 2, 0);
    plan_word(KIND_FILL, 0, 0, 38, 800, 1023, 0);
    // wholly below band 0
    plan_word(KIND_FILL, 0, 0, 40, 10, 50, 0, 0, 0, STATUS_OK);
    plan_word(KIND_READ, 0, 0, 0, 0, 0, 99);
    plan_word(KIND_START, 11, 0, 0, 0, 0, 0, 0, 0, STATUS_OK);
    plan_word(KIND_FILL, 0, 1023, 1023, 1023, 1023, 0, 0, 0, STATUS_OK);
    plan_word(KIND_FILL, 0, 0, 440, 8, 441, 0);
    plan_word(KIND_READ, 0, 0, 0, 0, 0, 0, 8'h00, 0, STATUS_OK);
    // red plane sets bits
    plan_reg(CFG_PLANE_COLOR, 1);
    plan_word(KIND_FILL, 0, 0, 440, 4, 441, 0);
    plan_word(KIND_READ, 0, 0, 0, 0, 0, 0, 8'hF0, 0, STATUS_OK);
    // widest panel, 34-row bands: rows 32 and 33 run past the buffer end
    plan_reg(CFG_PANEL_WIDTH, 1023);
    plan_reg(CFG_PANEL_HEIGHT, 1023);
    plan_reg(CFG_BAND_COUNT, 30);
    plan_word(KIND_START, 0, 0, 0, 0, 0, 0, 0, 0, STATUS_OK);
    plan_word(KIND_FILL, 0, 0, 33, 1023, 34, 0, 0, 0, STATUS_BEYOND);
    plan_word(KIND_FILL, 0, 0, 32, 1023, 33, 0);
    plan_word(KIND_READ, 0, 0, 0, 0, 0, 4095);
    // zero bands: every start is refused
    plan_reg(CFG_BAND_COUNT, 0);
    plan_word(KIND_START, 0, 0, 0, 0, 0, 0, 0, 0, STATUS_BAD_BAND);

    foreach (plan[i]) begin
      if (plan[i].is_reg) write_reg(plan[i].reg_index, plan[i].reg_value);
      else send_item(plan[i].word, plan[i].typed, plan[i].want);
    end

    // --- random phases; -1 picks a random setting ---
    for (ph = 0; ph < 9; ph++) begin
      write_reg(CFG_PANEL_WIDTH, CFG_DAT_W'(
                (ph_width[ph] < 0) ? $urandom_range(1, 1023) : ph_width[ph]));
      write_reg(CFG_PANEL_HEIGHT, CFG_DAT_W'(
                (ph_height[ph] < 0) ? $urandom_range(1, 1023) : ph_height[ph]));
      write_reg(CFG_BAND_COUNT, CFG_DAT_W'(
                (ph_bands[ph] < 0) ? $urandom_range(1, 255) : ph_bands[ph]));
      write_reg(CFG_PLANE_COLOR, CFG_DAT_W'(
                (ph_red[ph] < 0) ? $urandom_range(0, 1) : ph_red[ph]));

      repeat (PHASE_WORDS) begin
        // unused fields carry noise
        w.band       = BAND_W'($urandom_range(0, 255));
        w.x_first    = COORD_W'($urandom_range(0, 1023));
        w.y_first    = COORD_W'($urandom_range(0, 1023));
        w.x_end      = COORD_W'($urandom_range(0, 1023));
        w.y_end      = COORD_W'($urandom_range(0, 1023));
        w.byte_index = BYTE_IX_W'($urandom_range(0, 4095));
        pick = $urandom_range(0, 99);
        rows = int'(shadow_row_limit) - int'(shadow_first_row);

        if (pick < 5 || (pick >= 60 && pick < 95 && !buffer_live)) begin
          // mostly good bands; reads wait for the buffer to be cleared once
          w.kind = KIND_START;
          if (shadow_bands != 0 && $urandom_range(0, 7) != 0)
            w.band = BAND_W'($urandom_range(0, shadow_bands - 1));
        end else if (pick < 57) begin
          // small box around the selected band, edges a little outside it
          w.kind    = KIND_FILL;
          top       = int'(shadow_first_row) + int'($urandom_range(0, rows + 3)) - 2;
          w.y_first = to_coord(top);
          w.y_end   = to_coord(top + int'($urandom_range(0, 16)));
          w.x_first = to_coord(int'($urandom_range(0, shadow_width + 2)));
          w.x_end   = to_coord(int'(w.x_first) + int'($urandom_range(0, 64)));
        end else if (pick < 60) begin
          // any coordinates at all
          w.kind = KIND_FILL;
        end else if (pick < 95) begin
          // mostly bytes that hold band pixels
          w.kind = KIND_READ;
          span   = (rows * int'(shadow_width) + 7) / 8;
          if (span > 0 && $urandom_range(0, 4) != 0)
            w.byte_index = BYTE_IX_W'($urandom_range(0, lesser(span, BAND_BYTES) - 1));
        end else begin
          w.kind = KIND_IDLE;
        end

        // the block walks every clipped pixel; keep huge boxes rare
        if (w.kind == KIND_FILL) begin
          walk = greater(0, lesser(lesser(int'(w.y_end), int'(shadow_height)),
                                   int'(shadow_row_limit))
                            - greater(int'(w.y_first), int'(shadow_first_row)))
               * greater(0, lesser(int'(w.x_end), int'(shadow_width)) - int'(w.x_first));
          if (walk > WALK_CAP)
            w.y_end = to_coord(int'(w.y_first) + int'($urandom_range(0, 4)));
        end

        send_item(w, 1'b0, '0);
      end
    end

    item_valid <= 1'b0;
    cfg_valid  <= 1'b0;
    // a word never answered leaves this loop to the watchdog
    while (answers_due.size() != 0) @(posedge clk);
    // catch any stray word after the last one
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire

### files.f
rtl/bbrf_pkg.sv
rtl/bbrf_ram.sv
rtl/bbrf_div.sv
rtl/bbrf_datapath.sv
rtl/bbrf_ctrl.sv
rtl/banded_bitplane_rect_fill_top.sv
rtl/bbrf_checker.sv
dv/testbench.sv
